[hw/rtl/wav_header_scanner_assert.svh]
// ----------------------------------------------------------------------------
// wav_header_scanner_assert.svh
// Assertion macros shared by the header scanner modules.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_SCANNER_ASSERT_SVH
`define WAV_HEADER_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define WHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wav_header_scanner: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define WHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wav_header_scanner: next-cycle check failed");

`endif

[hw/rtl/whs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whs_pkg
// Types and constants of the WAV header scanner.
// ----------------------------------------------------------------------------
package whs_pkg;

	// Chunk tags as seen in a little-endian 32-bit shift of four bytes
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// Bytes in a tag or a size field, and in the parsed part of a fmt body
	localparam logic [4:0] FIELD_BYTES = 5'd4;
	localparam logic [4:0] FMT_BODY    = 5'd16;

	// Result item packing
	localparam int STATUS_W = 3;
	localparam int M_DATA_W = 88;

	typedef enum logic [3:0] {
		PH_RIFF,
		PH_RSIZE,
		PH_WAVE,
		PH_ID,
		PH_SIZE,
		PH_FMT,
		PH_SKIP,
		PH_DRAIN
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND,
		ST_BAD_RIFF,
		ST_BAD_WAVE,
		ST_NO_FMT,
		ST_ENDED
	} status_t;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [31:0] rate_hz;
		logic [15:0] channel_count;
		logic [31:0] data_len;
	} whs_result_t;

endpackage

[hw/rtl/whs_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whs_step
// Parser state and per-byte update: tag checks, chunk walk, fmt capture and
// skip count. Gives at most one result for each byte it is handed.
// ----------------------------------------------------------------------------
`include "wav_header_scanner_assert.svh"

module whs_step
	import whs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output whs_result_t res
);

	phase_t      phase_q, phase_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [32:0] skip_q, skip_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] size_q, size_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] chan_q, chan_d;
	logic        fmt_seen_q, fmt_seen_d;

	logic [31:0] tag_new;
	logic [31:0] size_new;
	logic [4:0]  cnt_inc;
	logic        field_done;
	logic [32:0] skip_round;
	logic [32:0] skip_fmt;
	logic [32:0] skip_dec;

	// Shift the new byte in from the top: little-endian assembly
	assign tag_new    = {data_byte, tag_q[31:8]};
	assign size_new   = {data_byte, size_q[31:8]};
	assign cnt_inc    = cnt_q + 5'd1;
	assign field_done = (cnt_inc == FIELD_BYTES);
	// Round an unknown chunk size up to even
	assign skip_round = {1'b0, size_new} + {32'd0, size_new[0]};
	// Excess of a fmt chunk beyond the parsed body
	assign skip_fmt   = (size_q > {27'd0, FMT_BODY})
		? {1'b0, size_q - {27'd0, FMT_BODY}} : 33'd0;
	assign skip_dec   = (skip_q != 33'd0) ? skip_q - 33'd1 : skip_q;

	// Next state
	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		skip_d     = skip_q;
		tag_d      = tag_q;
		size_d     = size_q;
		rate_d     = rate_q;
		chan_d     = chan_q;
		fmt_seen_d = fmt_seen_q;
		if (en) begin
			case (phase_q)
				PH_RIFF, PH_WAVE, PH_ID: begin
					tag_d = tag_new;
					cnt_d = field_done ? 5'd0 : cnt_inc;
					if (field_done) begin
						case (phase_q)
							PH_RIFF: if (tag_new == TAG_RIFF) phase_d = PH_RSIZE;
							PH_WAVE: if (tag_new == TAG_WAVE) phase_d = PH_ID;
							default: phase_d = PH_SIZE;
						endcase
					end
				end
				PH_RSIZE: begin
					cnt_d = field_done ? 5'd0 : cnt_inc;
					if (field_done) phase_d = PH_WAVE;
				end
				PH_SIZE: begin
					size_d = size_new;
					cnt_d  = field_done ? 5'd0 : cnt_inc;
					if (field_done && tag_q == TAG_FMT) begin
						phase_d = PH_FMT;
					end else if (field_done && tag_q != TAG_DATA) begin
						skip_d  = skip_round;
						phase_d = (skip_round == 33'd0) ? PH_ID : PH_SKIP;
					end
				end
				PH_FMT: begin
					case (cnt_q)
						5'd2:    chan_d[7:0]   = data_byte;
						5'd3:    chan_d[15:8]  = data_byte;
						5'd4:    rate_d[7:0]   = data_byte;
						5'd5:    rate_d[15:8]  = data_byte;
						5'd6:    rate_d[23:16] = data_byte;
						5'd7:    rate_d[31:24] = data_byte;
						default: ;
					endcase
					cnt_d = cnt_inc;
					if (cnt_inc == FMT_BODY) begin
						fmt_seen_d = 1'b1;
						skip_d     = skip_fmt;
						cnt_d      = 5'd0;
						phase_d    = (skip_fmt == 33'd0) ? PH_ID : PH_SKIP;
					end
				end
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == 33'd0) phase_d = PH_ID;
				end
				default: ;
			endcase

			// Rearm on the last byte; otherwise drain after a result
			if (last_byte) begin
				phase_d    = PH_RIFF;
				cnt_d      = 5'd0;
				skip_d     = 33'd0;
				tag_d      = 32'd0;
				size_d     = 32'd0;
				rate_d     = 32'd0;
				chan_d     = 16'd0;
				fmt_seen_d = 1'b0;
			end else if (res.valid) begin
				phase_d = PH_DRAIN;
			end
		end
	end

	// Result for the byte in hand
	always_comb begin
		logic    hit;
		status_t st;
		hit = 1'b0;
		st  = ST_ENDED;
		case (phase_q)
			PH_RIFF: if (field_done && tag_new != TAG_RIFF) begin
				hit = 1'b1;
				st  = ST_BAD_RIFF;
			end
			PH_WAVE: if (field_done && tag_new != TAG_WAVE) begin
				hit = 1'b1;
				st  = ST_BAD_WAVE;
			end
			PH_SIZE: if (field_done && tag_q == TAG_DATA) begin
				hit = 1'b1;
				st  = fmt_seen_q ? ST_FOUND : ST_NO_FMT;
			end
			default: ;
		endcase
		res.valid         = en && (hit || (last_byte && phase_q != PH_DRAIN));
		res.status        = st;
		res.rate_hz       = (st == ST_FOUND) ? rate_q : 32'd0;
		res.channel_count = (st == ST_FOUND) ? chan_q : 16'd0;
		res.data_len      = (st == ST_FOUND || st == ST_NO_FMT) ? size_new : 32'd0;
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RIFF;
			cnt_q      <= 5'd0;
			skip_q     <= 33'd0;
			tag_q      <= 32'd0;
			size_q     <= 32'd0;
			rate_q     <= 32'd0;
			chan_q     <= 16'd0;
			fmt_seen_q <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			skip_q     <= skip_d;
			tag_q      <= tag_d;
			size_q     <= size_d;
			rate_q     <= rate_d;
			chan_q     <= chan_d;
			fmt_seen_q <= fmt_seen_d;
		end
	end

	`WHS_ASSERT_NEXT(a_rearm_on_last, clk, arst_n, en && last_byte, phase_q == PH_RIFF && !fmt_seen_q && cnt_q == 5'd0)
	`WHS_ASSERT_NOW(a_drain_silent, clk, arst_n, phase_q == PH_DRAIN, !res.valid)
	`WHS_ASSERT_NOW(a_skip_nonzero, clk, arst_n, phase_q == PH_SKIP, skip_q != 33'd0)

endmodule

[hw/rtl/wav_header_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_scanner
// RIFF/WAVE header scanner: takes a file one byte per item and reports the
// format and data size at the data chunk, or an error status.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                        | tlast
//  s_axis   | in  | [7:0] data_byte                              | last_byte
//  m_axis   | out | [2:0] status, [34:3] rate_hz,                | -
//           |     | [50:35] channel_count, [82:51] data_len      |
//
//  One byte item per cycle sustained while m_axis_tready does not stall the result;
//  a result item comes from its byte by way of the input register, then the parser step into the result register.
//  The parser step is a single pass over small counters and shift registers.
//  Reset clears the parser back to expecting the RIFF tag.
//  A stalled result holds the input register; s_axis_tready stays high while
//  the result register is empty or being taken.
// ----------------------------------------------------------------------------
`include "wav_header_scanner_assert.svh"

module wav_header_scanner
	import whs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
	input  logic                s_axis_tlast,  // last_byte
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata   // status, rate_hz, channel_count, data_len
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        advance;
	whs_result_t res;
	logic        m_valid_q;
	whs_result_t res_q;

	// Move the held byte into the parser when the result slot can take a result
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	whs_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= res.valid;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'd0, res_q.data_len, res_q.channel_count,
		res_q.rate_hz, res_q.status};

	`WHS_ASSERT_NOW(a_no_overwrite, clk, arst_n, m_axis_tvalid && !m_axis_tready, !advance)
	`WHS_ASSERT_NOW(a_status_range, clk, arst_n, m_axis_tvalid, res_q.status <= ST_ENDED)
	`WHS_ASSERT_NOW(a_error_no_format, clk, arst_n, m_axis_tvalid && res_q.status != ST_FOUND, res_q.rate_hz == 32'd0 && res_q.channel_count == 16'd0)

endmodule
